/* rtl/nllm_pkg.sv */
// Shared types and constants for the node liveness indicator monitor.
package nllm_pkg;

  localparam int NodeCountDef = 16;
  localparam int TimeBitsDef  = 48;
  localparam int LedW         = 16;
  localparam int NowW         = 48;
  localparam int TimeoutW     = 32;

  localparam logic [TimeoutW-1:0] TimeoutRst = 32'd30000000;
  localparam logic [7:0]          MinMsgLen  = 8'd2;

  localparam logic [1:0] KindStatus   = 2'd0;
  localparam logic [1:0] KindTick     = 2'd1;
  localparam logic [1:0] KindProvDone = 2'd2;
  localparam logic [1:0] KindProvRst  = 2'd3;

  localparam logic [1:0] ModeOff   = 2'd0;
  localparam logic [1:0] ModeSolid = 2'd1;
  localparam logic [1:0] ModeBlink = 2'd2;

  typedef struct packed {
    logic            valid;
    logic [1:0]      kind;
    logic [7:0]      idx;
    logic            alarm;
    logic            prov;
    logic            ignored;
    logic [LedW-1:0] green;
    logic [LedW-1:0] red;
    logic [LedW-1:0] heard;
    logic [LedW-1:0] tmo;
  } nllm_req_t;

endpackage

/* rtl/nllm_cell.sv */
// One node cell: holds the node state, applies the passing request, hands it on.
module nllm_cell
  import nllm_pkg::*;
#(
  parameter int IDX       = 0,
  parameter int TIME_BITS = TimeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic [TimeoutW-1:0]  timeout_i,
  input  nllm_req_t            req_i,
  input  logic [TIME_BITS-1:0] now_i,
  output nllm_req_t            req_o,
  output logic [TIME_BITS-1:0] now_o
);

  logic [1:0]           mode_q, mode_d;
  logic                 green_q, green_d;
  logic                 red_q, red_d;
  logic                 heard_q, heard_d;
  logic [TIME_BITS-1:0] stamp_q, stamp_d;
  logic                 tmo_d;
  logic [TIME_BITS-1:0] elapsed;
  logic                 expired;
  nllm_req_t            req_q, req_d;
  logic [TIME_BITS-1:0] now_q;

  assign elapsed = now_i - stamp_q;
  assign expired = (stamp_q != '0) && (elapsed > TIME_BITS'(timeout_i));

  always_comb begin
    mode_d  = mode_q;
    green_d = green_q;
    red_d   = red_q;
    heard_d = heard_q;
    stamp_d = stamp_q;
    tmo_d   = 1'b0;
    case (req_i.kind)
      KindStatus: begin
        if (!req_i.ignored && (req_i.idx == 8'(IDX))) begin
          heard_d = 1'b1;
          red_d   = req_i.alarm;
          stamp_d = now_i;
          mode_d  = ModeBlink;
        end
      end
      KindTick: begin
        if (req_i.prov) begin
          case (mode_q)
            ModeBlink: begin
              if (expired) begin
                mode_d  = ModeSolid;
                green_d = 1'b1;
                tmo_d   = 1'b1;
              end else begin
                green_d = ~green_q;
              end
            end
            ModeSolid: green_d = 1'b1;
            default:   green_d = 1'b0;
          endcase
        end
      end
      KindProvDone: begin
        mode_d  = ModeSolid;
        green_d = 1'b1;
        stamp_d = '0;
      end
      default: begin
        mode_d  = ModeOff;
        green_d = 1'b0;
        red_d   = 1'b0;
        heard_d = 1'b0;
        stamp_d = '0;
      end
    endcase
  end

  always_comb begin
    req_d            = req_i;
    req_d.green[IDX] = green_d;
    req_d.red[IDX]   = red_d;
    req_d.heard[IDX] = heard_d;
    req_d.tmo[IDX]   = tmo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeOff;
      green_q <= 1'b0;
      red_q   <= 1'b0;
      heard_q <= 1'b0;
      stamp_q <= '0;
    end else if (adv_i && req_i.valid) begin
      mode_q  <= mode_d;
      green_q <= green_d;
      red_q   <= red_d;
      heard_q <= heard_d;
      stamp_q <= stamp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
      now_q <= '0;
    end else if (adv_i) begin
      req_q <= req_d;
      now_q <= now_i;
    end
  end

  assign req_o = req_q;
  assign now_o = now_q;

endmodule

/* rtl/node_liveness_led_monitor.sv */
// Top level of the node liveness indicator monitor: request head, cell chain, result register.
//
// Each accepted request walks a chain of NODE_COUNT node cells, one cell per cycle while the
// result is not stalled, and each cell updates its own node and adds that node's indicator
// bits to the request. The result is registered after the last cell, and the next request is
// taken in the cycle after the previous one leaves the last cell, so only one request is in
// the chain at a time. A stalled result holds the whole chain.
// Write the timeout register only while no request is in flight; cfg_ready_o is always high.
module node_liveness_led_monitor
  import nllm_pkg::*;
#(
  parameter int NODE_COUNT = NodeCountDef,
  parameter int TIME_BITS  = TimeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [TimeoutW-1:0] cfg_node_timeout_us_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          mode_i,
  input  logic [7:0]          node_index_i,
  input  logic [7:0]          alarm_state_i,
  input  logic [7:0]          msg_length_i,
  input  logic [NowW-1:0]     now_us_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [LedW-1:0]     green_leds_o,
  output logic [LedW-1:0]     red_leds_o,
  output logic [LedW-1:0]     heard_nodes_o,
  output logic [LedW-1:0]     timed_out_nodes_o,
  output logic                provisioned_o,
  output logic                item_ignored_o
);

  logic [TimeoutW-1:0]  timeout_q;
  logic                 prov_q, prov_d;
  logic                 busy_q;
  logic                 accept;
  logic                 adv;
  logic                 done;
  nllm_req_t            head_q, head_d;
  logic [TIME_BITS-1:0] head_now_q;
  nllm_req_t            chain [NODE_COUNT+1];
  logic [TIME_BITS-1:0] now_chain [NODE_COUNT+1];
  logic [NODE_COUNT:0]  chain_vld;
  nllm_req_t            out_q;
  logic                 out_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= cfg_node_timeout_us_i;
    end
  end

  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign adv        = !(out_valid_q && out_stall_i);
  assign done       = adv && chain[NODE_COUNT].valid;

  always_comb begin
    case (mode_i)
      KindProvDone: prov_d = 1'b1;
      KindProvRst:  prov_d = 1'b0;
      default:      prov_d = prov_q;
    endcase
  end

  always_comb begin
    head_d         = '0;
    head_d.valid   = 1'b1;
    head_d.kind    = mode_i;
    head_d.idx     = node_index_i;
    head_d.alarm   = |alarm_state_i;
    head_d.prov    = prov_d;
    head_d.ignored = (mode_i == KindStatus) &&
                     ((msg_length_i < MinMsgLen) || (node_index_i >= 8'(NODE_COUNT)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prov_q     <= 1'b0;
      busy_q     <= 1'b0;
      head_q     <= '0;
      head_now_q <= '0;
    end else begin
      if (accept) begin
        prov_q     <= prov_d;
        busy_q     <= 1'b1;
        head_q     <= head_d;
        head_now_q <= TIME_BITS'(now_us_i);
      end else begin
        if (done) begin
          busy_q <= 1'b0;
        end
        if (adv) begin
          head_q.valid <= 1'b0;
        end
      end
    end
  end

  assign chain[0]     = head_q;
  assign now_chain[0] = head_now_q;

  for (genvar i = 0; i < NODE_COUNT; i++) begin : g_cell
    nllm_cell #(
      .IDX      (i),
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .timeout_i(timeout_q),
      .req_i    (chain[i]),
      .now_i    (now_chain[i]),
      .req_o    (chain[i+1]),
      .now_o    (now_chain[i+1])
    );
  end

  for (genvar i = 0; i <= NODE_COUNT; i++) begin : g_vld
    assign chain_vld[i] = chain[i].valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= chain[NODE_COUNT];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign green_leds_o      = out_q.green;
  assign red_leds_o        = out_q.red;
  assign heard_nodes_o     = out_q.heard;
  assign timed_out_nodes_o = out_q.tmo;
  assign provisioned_o     = out_q.prov;
  assign item_ignored_o    = out_q.ignored;

  a_single_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(chain_vld) <= 1)
    else $error("more than one request in the cell chain");

  a_busy_tracks_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_vld != '0) |-> busy_q)
    else $error("request in the chain while the monitor is idle");

  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (out_valid_q && !busy_q))
    else $error("finished request not moved to the result register");

  a_ignored_no_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && item_ignored_o) |-> (timed_out_nodes_o == '0))
    else $error("dropped status request reports timed out nodes");

endmodule

/* test/tb_node_liveness_led_monitor.sv */
// Self-checking testbench for the node liveness indicator monitor.
module tb_node_liveness_led_monitor;
  import nllm_pkg::*;

  localparam int Nodes    = NodeCountDef;
  localparam int DirCount = 24;
  localparam int Phases   = 10;
  localparam int PhaseLen = 230;
  localparam int Settle   = NodeCountDef + 4;

  typedef struct packed {
    logic [LedW-1:0] green;
    logic [LedW-1:0] red;
    logic [LedW-1:0] heard;
    logic [LedW-1:0] tmo;
    logic            prov;
    logic            ign;
  } led_result_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      idx;
    logic [7:0]      alarm;
    logic [7:0]      len;
    logic [NowW-1:0] now;
    logic            typed;
    led_result_t     want;
  } stim_row_t;

  localparam led_result_t NoCheck = '0;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [TimeoutW-1:0] cfg_node_timeout_us_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          mode_i = KindTick;
  logic [7:0]          node_index_i = '0;
  logic [7:0]          alarm_state_i = '0;
  logic [7:0]          msg_length_i = '0;
  logic [NowW-1:0]     now_us_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [LedW-1:0]     green_leds_o;
  logic [LedW-1:0]     red_leds_o;
  logic [LedW-1:0]     heard_nodes_o;
  logic [LedW-1:0]     timed_out_nodes_o;
  logic                provisioned_o;
  logic                item_ignored_o;

  logic        req_typed = 1'b0;
  led_result_t req_want = '0;

  // predictor state
  logic [1:0]          nd_mode [Nodes];
  logic [NowW-1:0]     nd_stamp [Nodes];
  logic [Nodes-1:0]    nd_green;
  logic [Nodes-1:0]    nd_red;
  logic [Nodes-1:0]    nd_heard;
  logic                prov_flag;
  logic [TimeoutW-1:0] timeout_us;

  led_result_t expected_leds [$];
  led_result_t want_leds;
  led_result_t got_leds;
  int          err_count = 0;
  bit          long_hold_req = 1'b0;
  logic [NowW-1:0] clock_us = '0;
  int          burst_left = 0;

  stim_row_t dir_rows [DirCount] = '{
    '{KindTick, 8'd0, 8'd0, 8'd0, 48'd100, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0}},
    '{KindStatus, 8'd0, 8'd0, 8'd2, 48'd0, 1'b1,
      '{16'h0000, 16'h0000, 16'h0001, 16'h0000, 1'b0, 1'b0}},
    '{KindStatus, 8'd1, 8'd1, 8'd1, 48'd50, 1'b1,
      '{16'h0000, 16'h0000, 16'h0001, 16'h0000, 1'b0, 1'b1}},
    '{KindStatus, 8'd2, 8'd1, 8'd0, 48'd60, 1'b1,
      '{16'h0000, 16'h0000, 16'h0001, 16'h0000, 1'b0, 1'b1}},
    '{KindStatus, 8'd16, 8'd1, 8'd255, 48'd70, 1'b1,
      '{16'h0000, 16'h0000, 16'h0001, 16'h0000, 1'b0, 1'b1}},
    '{KindStatus, 8'd255, 8'd255, 8'd2, 48'd80, 1'b1,
      '{16'h0000, 16'h0000, 16'h0001, 16'h0000, 1'b0, 1'b1}},
    '{KindStatus, 8'd15, 8'd255, 8'd255, 48'hFFFF_FFFF_FFFF, 1'b1,
      '{16'h0000, 16'h8000, 16'h8001, 16'h0000, 1'b0, 1'b0}},
    '{KindStatus, 8'd3, 8'd1, 8'd2, 48'd1000, 1'b1,
      '{16'h0000, 16'h8008, 16'h8009, 16'h0000, 1'b0, 1'b0}},
    '{KindTick, 8'd0, 8'd0, 8'd0, 48'd2000, 1'b1,
      '{16'h0000, 16'h8008, 16'h8009, 16'h0000, 1'b0, 1'b0}},
    '{KindProvDone, 8'hFF, 8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF, 1'b1,
      '{16'hFFFF, 16'h8008, 16'h8009, 16'h0000, 1'b1, 1'b0}},
    '{KindTick, 8'd0, 8'd0, 8'd0, 48'd5000, 1'b1,
      '{16'hFFFF, 16'h8008, 16'h8009, 16'h0000, 1'b1, 1'b0}},
    '{KindStatus, 8'd3, 8'd0, 8'd2, 48'd1000, 1'b1,
      '{16'hFFFF, 16'h8000, 16'h8009, 16'h0000, 1'b1, 1'b0}},
    '{KindStatus, 8'd5, 8'd128, 8'd3, 48'd0, 1'b0, NoCheck},
    '{KindStatus, 8'd15, 8'd1, 8'd2, 48'hFFFF_FFFF_FFF0, 1'b0, NoCheck},
    '{KindTick, 8'd0, 8'd0, 8'd0, 48'd1000, 1'b0, NoCheck},
    '{KindTick, 8'd0, 8'd0, 8'd0, 48'd30001000, 1'b0, NoCheck},
    '{KindTick, 8'd0, 8'd0, 8'd0, 48'd30001001, 1'b0, NoCheck},
    '{KindTick, 8'd0, 8'd0, 8'd0, 48'hFFFF_FFFF_FFFF, 1'b0, NoCheck},
    '{KindProvRst, 8'hFF, 8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0}},
    '{KindStatus, 8'd7, 8'd2, 8'd2, 48'd5, 1'b1,
      '{16'h0000, 16'h0080, 16'h0080, 16'h0000, 1'b0, 1'b0}},
    '{KindTick, 8'd0, 8'd0, 8'd0, 48'd10, 1'b1,
      '{16'h0000, 16'h0080, 16'h0080, 16'h0000, 1'b0, 1'b0}},
    '{KindProvDone, 8'd0, 8'd0, 8'd0, 48'd0, 1'b1,
      '{16'hFFFF, 16'h0080, 16'h0080, 16'h0000, 1'b1, 1'b0}},
    '{KindStatus, 8'd9, 8'd0, 8'd200, 48'd123456, 1'b0, NoCheck},
    '{KindTick, 8'd0, 8'd0, 8'd0, 48'd123456, 1'b0, NoCheck}
  };

  logic [TimeoutW-1:0] phase_timeout [Phases] = '{
    32'd0, 32'hFFFF_FFFF, 32'd1000, 32'd30000000, 32'd1,
    32'd250000, 32'd0, 32'd5000, 32'hFFFF_FFFF, 32'd30000000
  };

  node_liveness_led_monitor dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_node_timeout_us_i (cfg_node_timeout_us_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .mode_i                (mode_i),
    .node_index_i          (node_index_i),
    .alarm_state_i         (alarm_state_i),
    .msg_length_i          (msg_length_i),
    .now_us_i              (now_us_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .green_leds_o          (green_leds_o),
    .red_leds_o            (red_leds_o),
    .heard_nodes_o         (heard_nodes_o),
    .timed_out_nodes_o     (timed_out_nodes_o),
    .provisioned_o         (provisioned_o),
    .item_ignored_o        (item_ignored_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic led_result_t predict_leds(input logic [1:0] kind, input logic [7:0] idx,
                                               input logic [7:0] alarm, input logic [7:0] len,
                                               input logic [NowW-1:0] now);
    led_result_t     res;
    logic [NowW-1:0] elapsed;
    res = '0;
    case (kind)
      KindStatus: begin
        if (len < MinMsgLen || idx >= 8'(Nodes)) begin
          res.ign = 1'b1;
        end else begin
          nd_heard[idx] = 1'b1;
          nd_red[idx]   = (alarm != 8'd0);
          nd_stamp[idx] = now;
          nd_mode[idx]  = ModeBlink;
        end
      end
      KindTick: begin
        if (prov_flag) begin
          for (int i = 0; i < Nodes; i++) begin
            if (nd_mode[i] == ModeBlink) begin
              elapsed = now - nd_stamp[i];
              if (nd_stamp[i] != '0 && elapsed > NowW'(timeout_us)) begin
                nd_mode[i]  = ModeSolid;
                nd_green[i] = 1'b1;
                res.tmo[i]  = 1'b1;
              end else begin
                nd_green[i] = ~nd_green[i];
              end
            end else if (nd_mode[i] == ModeSolid) begin
              nd_green[i] = 1'b1;
            end else begin
              nd_green[i] = 1'b0;
            end
          end
        end
      end
      KindProvDone: begin
        prov_flag = 1'b1;
        for (int i = 0; i < Nodes; i++) begin
          nd_mode[i]  = ModeSolid;
          nd_stamp[i] = '0;
        end
        nd_green = '1;
      end
      default: begin
        prov_flag = 1'b0;
        for (int i = 0; i < Nodes; i++) begin
          nd_mode[i]  = ModeOff;
          nd_stamp[i] = '0;
        end
        nd_green = '0;
        nd_red   = '0;
        nd_heard = '0;
      end
    endcase
    res.green = nd_green;
    res.red   = nd_red;
    res.heard = nd_heard;
    res.prov  = prov_flag;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_count < 50) begin
      $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    end
    err_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want_leds = predict_leds(mode_i, node_index_i, alarm_state_i, msg_length_i, now_us_i);
        if (req_typed) begin
          want_leds = req_want;
        end
        expected_leds.push_back(want_leds);
      end
      if (out_valid_o && !out_stall_i) begin
        got_leds = '{green_leds_o, red_leds_o, heard_nodes_o, timed_out_nodes_o,
                     provisioned_o, item_ignored_o};
        if (expected_leds.size() == 0) begin
          report_mismatch("unexpected result",
                          {got_leds.green, got_leds.red, got_leds.heard, got_leds.tmo}, '0);
        end else begin
          want_leds = expected_leds.pop_front();
          if (got_leds.green !== want_leds.green)
            report_mismatch("green_leds", 64'(got_leds.green), 64'(want_leds.green));
          if (got_leds.red !== want_leds.red)
            report_mismatch("red_leds", 64'(got_leds.red), 64'(want_leds.red));
          if (got_leds.heard !== want_leds.heard)
            report_mismatch("heard_nodes", 64'(got_leds.heard), 64'(want_leds.heard));
          if (got_leds.tmo !== want_leds.tmo)
            report_mismatch("timed_out_nodes", 64'(got_leds.tmo), 64'(want_leds.tmo));
          if (got_leds.prov !== want_leds.prov)
            report_mismatch("provisioned", 64'(got_leds.prov), 64'(want_leds.prov));
          if (got_leds.ign !== want_leds.ign)
            report_mismatch("item_ignored", 64'(got_leds.ign), 64'(want_leds.ign));
        end
      end
    end
  end

  task automatic write_timeout(input logic [TimeoutW-1:0] value);
    cfg_valid_i           <= 1'b1;
    cfg_node_timeout_us_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    timeout_us = value;
  endtask

  task automatic offer_request(input logic [1:0] kind, input logic [7:0] idx,
                               input logic [7:0] alarm, input logic [7:0] len,
                               input logic [NowW-1:0] now, input logic typed,
                               input led_result_t want);
    in_valid_i    <= 1'b1;
    mode_i        <= kind;
    node_index_i  <= idx;
    alarm_state_i <= alarm;
    msg_length_i  <= len;
    now_us_i      <= now;
    req_typed     <= typed;
    req_want      <= want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // end a burst with a random gap
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_leds.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic random_request();
    logic [1:0] kind;
    logic [7:0] idx;
    logic [7:0] alarm;
    logic [7:0] len;
    int         pick;
    pick  = $urandom_range(0, 29);
    kind  = (pick < 14) ? KindStatus : (pick < 27) ? KindTick :
            (pick < 29) ? KindProvDone : KindProvRst;
    idx   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, Nodes - 1));
    len   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1)) :
                                          8'($urandom_range(2, 255));
    alarm = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
    pick  = $urandom_range(0, 19);
    if (pick < 7) begin
      clock_us = clock_us + NowW'($urandom_range(0, 1000));
    end else if (pick < 18) begin
      clock_us = clock_us + NowW'($urandom_range(0, timeout_us)) +
                 NowW'($urandom_range(0, timeout_us / 2));
    end else if (pick == 18) begin
      clock_us = {16'($urandom), 32'($urandom)};
    end else begin
      clock_us = '0;
    end
    offer_request(kind, idx, alarm, len, clock_us, 1'b0, NoCheck);
  endtask

  initial begin
    timeout_us = TimeoutRst;
    prov_flag  = 1'b0;
    nd_green   = '0;
    nd_red     = '0;
    nd_heard   = '0;
    for (int i = 0; i < Nodes; i++) begin
      nd_mode[i]  = ModeOff;
      nd_stamp[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[r]) begin
      offer_request(dir_rows[r].kind, dir_rows[r].idx, dir_rows[r].alarm, dir_rows[r].len,
                    dir_rows[r].now, dir_rows[r].typed, dir_rows[r].want);
      pace_sender();
    end
    drain_results();
    for (int p = 0; p < Phases; p++) begin
      write_timeout((p == 6) ? 32'($urandom) : phase_timeout[p]);
      if (p == 2) begin
        long_hold_req = 1'b1;
      end
      for (int n = 0; n < PhaseLen; n++) begin
        random_request();
        pace_sender();
        if (n == PhaseLen / 2 && p % 3 == 0) begin
          drain_results();
        end
      end
      drain_results();
    end
    if (err_count == 0) begin
      $display("tb_node_liveness_led_monitor passed");
    end else begin
      $display("tb_node_liveness_led_monitor failed");
    end
    $finish;
  end

  initial begin
    int pct;
    int seg;
    forever begin
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else begin
        case ($urandom_range(0, 4))
          0, 1:    pct = 0;
          2:       pct = 25;
          3:       pct = 50;
          default: pct = 80;
        endcase
        seg = $urandom_range(16, 128);
        repeat (seg) begin
          out_stall_i <= ($urandom_range(0, 99) < pct);
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    #(4 * 2000000);
    $display("tb_node_liveness_led_monitor failed");
    $finish;
  end

endmodule
